### hdl/fet_pkg.sv
package fet_pkg;

    localparam int INDEX_W     = 11;
    localparam int COUNT_W     = INDEX_W + 1;
    localparam int ENTRY_COUNT = 1 << INDEX_W;
    localparam int WORD_W      = 32;
    localparam int KIND_W      = 4;
    localparam int NAME_CHARS  = 8;
    localparam int HALF_CHARS  = 4;
    localparam int CHAR_STEP   = 6;

    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_FIND_KIND = 2'd1;
    localparam logic [1:0] OP_FIND_NAME = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear;   // mark the entry at the clear counter unwritten, advance
        logic load;    // capture a new transaction
        logic issue;   // read the table at the current address, advance
        logic finish;  // post the result
        logic hit;     // result carries a match
    } fet_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last; // clear counter is at the final entry
        logic hit;        // entry read last cycle matches
        logic last;       // current address is the final one to read
    } fet_status_t;

endpackage

### hdl/fet_ctrl.sv
module fet_ctrl
    import fet_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  opcode,
    input  fet_status_t status,
    output fet_cmd_t    cmd,
    output logic        busy
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                // sweep the table once after reset, one entry per cycle
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (opcode == OP_FIND_KIND || opcode == OP_FIND_NAME)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        // write or unused opcode: answer at once, no match
                        cmd.finish = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (status.hit)
                begin
                    cmd.finish = 1'b1;
                    cmd.hit    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.issue = 1'b1;
                    if (status.last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                cmd.finish = 1'b1;
                cmd.hit    = status.hit;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### hdl/fet_datapath.sv
module fet_datapath
    import fet_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fet_cmd_t                      cmd,
    input  logic [1:0]                    opcode,
    input  logic [INDEX_W-1:0]            entry_index,
    input  logic [WORD_W-1:0]             write_name_low,
    input  logic [WORD_W-1:0]             write_name_high,
    input  logic [KIND_W-1:0]             file_kind,
    input  logic                          search_backward,
    input  logic [8*NAME_CHARS-1:0]       name_bytes,
    output fet_status_t                   status,
    output logic                          done,
    output logic                          found,
    output logic [INDEX_W-1:0]            match_index
);

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word_low;
        logic [WORD_W-1:0] word_high;
        logic [KIND_W-1:0] kind;
    } entry_t;

    entry_t mem [ENTRY_COUNT];

    entry_t               rd_entry_reg;
    logic [INDEX_W-1:0]   chk_index_reg;
    logic                 chk_valid_reg;
    logic [INDEX_W-1:0]   clr_addr_reg;
    logic [INDEX_W-1:0]   addr_reg;
    logic [INDEX_W-1:0]   addr_next;
    logic [COUNT_W-1:0]   remain_reg;
    logic [COUNT_W-1:0]   remain_next;
    logic                 backward_reg;
    logic                 name_mode_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [WORD_W-1:0]    pack_low_reg;
    logic [WORD_W-1:0]    pack_high_reg;
    logic [WORD_W-1:0]    pack_low;
    logic [WORD_W-1:0]    pack_high;
    logic                 done_reg;
    logic                 found_reg;
    logic [INDEX_W-1:0]   match_index_reg;

    // Pack the name: signed byte minus 0x20, six bits apart, stop at NUL or '.'
    always_comb
    begin
        logic [7:0]        ch;
        logic [WORD_W-1:0] val;
        logic              running;
        pack_low  = '0;
        pack_high = '0;
        running   = 1'b1;
        for (int k = 0; k < NAME_CHARS; k++)
        begin
            ch = name_bytes[8*k +: 8];
            if (ch == 8'h00 || ch == 8'h2E)
            begin
                running = 1'b0;
            end
            val = {{(WORD_W-8){ch[7]}}, ch} - WORD_W'(32'h20);
            val = val << (CHAR_STEP * (k % HALF_CHARS));
            if (running)
            begin
                if (k < HALF_CHARS)
                begin
                    pack_low = pack_low | val;
                end
                else
                begin
                    pack_high = pack_high | val;
                end
            end
        end
    end

    // First address and scan length of a new search, and their step on each issue
    always_comb
    begin
        addr_next   = addr_reg;
        remain_next = remain_reg;
        if (cmd.load)
        begin
            if (opcode == OP_FIND_KIND)
            begin
                addr_next   = search_backward ? entry_index - 1'b1 : entry_index + 1'b1;
                remain_next = COUNT_W'(ENTRY_COUNT);
            end
            else
            begin
                addr_next   = entry_index;
                remain_next = COUNT_W'(ENTRY_COUNT) - {1'b0, entry_index};
            end
        end
        else if (cmd.issue)
        begin
            addr_next   = backward_reg ? addr_reg - 1'b1 : addr_reg + 1'b1;
            remain_next = remain_reg - 1'b1;
        end
    end

    // Table storage: clear after reset, write on a write transaction,
    // read each issued address
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (cmd.load && opcode == OP_WRITE)
        begin
            mem[entry_index] <= '{valid: 1'b1,
                                  word_low: write_name_low,
                                  word_high: write_name_high,
                                  kind: file_kind};
        end
        if (cmd.issue)
        begin
            rd_entry_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        remain_reg <= remain_next;
        if (cmd.issue)
        begin
            chk_index_reg <= addr_reg;
        end
        if (cmd.load)
        begin
            backward_reg  <= (opcode == OP_FIND_KIND) && search_backward;
            name_mode_reg <= (opcode == OP_FIND_NAME);
            kind_reg      <= file_kind;
            pack_low_reg  <= pack_low;
            pack_high_reg <= pack_high;
        end
        if (cmd.finish)
        begin
            found_reg       <= cmd.hit;
            match_index_reg <= cmd.hit ? chk_index_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            clr_addr_reg  <= '0;
        end
        else
        begin
            chk_valid_reg <= cmd.issue;
            done_reg      <= cmd.finish;
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    assign status.hit = chk_valid_reg
                        && rd_entry_reg.valid
                        && (rd_entry_reg.kind == kind_reg)
                        && (!name_mode_reg
                            || (rd_entry_reg.word_low == pack_low_reg
                                && rd_entry_reg.word_high == pack_high_reg));
    assign status.last       = (remain_reg == COUNT_W'(1));
    assign status.clear_last = (clr_addr_reg == INDEX_W'(ENTRY_COUNT - 1));

    assign done        = done_reg;
    assign found       = found_reg;
    assign match_index = match_index_reg;

endmodule

### hdl/file_entry_table_search.sv
// Results: a write or unused opcode posts its result without a scan. A search reads the
// table one entry per cycle, registers each entry read and compares it, and posts at the
// first match or after N entries on a miss (N = entries scanned: the whole table for a
// type search, table size minus start for a name search). One transaction at a time.
// Reset (rst_n, async, active low) clears the controller and the result strobe; busy then
// holds while every entry is marked unwritten. done cannot be stalled.
module file_entry_table_search
    import fet_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               opcode,
    input  logic [INDEX_W-1:0]       entry_index,
    input  logic [WORD_W-1:0]        write_name_low,
    input  logic [WORD_W-1:0]        write_name_high,
    input  logic [KIND_W-1:0]        file_kind,
    input  logic                     search_backward,
    input  logic [8*NAME_CHARS-1:0]  name_bytes,
    output logic                     done,
    output logic                     found,
    output logic [INDEX_W-1:0]       match_index
);

    // Controller sequences the clearing pass and the scan; datapath holds the
    // table with its written flags, the clear and address counters, the
    // registered read/compare pipeline and the result registers.
    fet_cmd_t    cmd;
    fet_status_t status;

    fet_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    fet_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .opcode          (opcode),
        .entry_index     (entry_index),
        .write_name_low  (write_name_low),
        .write_name_high (write_name_high),
        .file_kind       (file_kind),
        .search_backward (search_backward),
        .name_bytes      (name_bytes),
        .status          (status),
        .done            (done),
        .found           (found),
        .match_index     (match_index)
    );

endmodule

### test/file_entry_table_search_check.sv
`timescale 1ns / 1ps
module file_entry_table_search_check
    import fet_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [1:0]               opcode,
    input  logic [INDEX_W-1:0]       entry_index,
    input  logic [WORD_W-1:0]        write_name_low,
    input  logic [WORD_W-1:0]        write_name_high,
    input  logic [KIND_W-1:0]        file_kind,
    input  logic                     search_backward,
    input  logic [8*NAME_CHARS-1:0]  name_bytes,
    input  logic                     done,
    input  logic                     found,
    input  logic [INDEX_W-1:0]       match_index,
    output int                       mismatches,
    output int                       outstanding
);

    localparam logic [WORD_W-1:0] CHAR_BIAS = 32'h20;
    localparam logic [7:0]        NAME_NUL  = 8'h00;
    localparam logic [7:0]        NAME_DOT  = 8'h2E;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
    } lookup_reply_t;

    // Shadow copy of the entry table
    logic [WORD_W-1:0] name_low_tab  [ENTRY_COUNT];
    logic [WORD_W-1:0] name_high_tab [ENTRY_COUNT];
    logic [KIND_W-1:0] kind_tab      [ENTRY_COUNT];
    bit                written_tab   [ENTRY_COUNT];

    lookup_reply_t expected_replies [$];
    int            fail_count = 0;

    assign mismatches = fail_count;

    // Pack up to eight characters into two words, six bits per character
    function automatic logic [2*WORD_W-1:0] packed_name(input logic [8*NAME_CHARS-1:0] chars);
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] code;
        logic [7:0]        ch;
        int                shift;
        bit                stopped;
        lo      = '0;
        hi      = '0;
        shift   = 0;
        stopped = 1'b0;
        for (int k = 0; k < NAME_CHARS; k++)
        begin
            ch = chars[8*k +: 8];
            if (k == HALF_CHARS)
                shift = 0;
            if (ch == NAME_NUL || ch == NAME_DOT)
                stopped = 1'b1;
            if (!stopped)
            begin
                code = {{(WORD_W-8){ch[7]}}, ch} - CHAR_BIAS;
                if (k < HALF_CHARS)
                    lo |= code << shift;
                else
                    hi |= code << shift;
                shift += CHAR_STEP;
            end
        end
        return {hi, lo};
    endfunction

    // Apply one transaction to the shadow table and work out its reply
    function automatic lookup_reply_t predict_lookup(
        input logic [1:0]              op,
        input logic [INDEX_W-1:0]      idx,
        input logic [WORD_W-1:0]       lo,
        input logic [WORD_W-1:0]       hi,
        input logic [KIND_W-1:0]       kind,
        input logic                    back,
        input logic [8*NAME_CHARS-1:0] chars
    );
        lookup_reply_t     reply;
        logic [2*WORD_W-1:0] words;
        int unsigned       pos;
        reply = '0;
        case (op)
            OP_WRITE:
            begin
                name_low_tab[idx]  = lo;
                name_high_tab[idx] = hi;
                kind_tab[idx]      = kind;
                written_tab[idx]   = 1'b1;
            end
            OP_FIND_KIND:
            begin
                pos = back ? idx - 1 : idx + 1;
                for (int n = 0; n < ENTRY_COUNT && !reply.found; n++)
                begin
                    if (pos >= ENTRY_COUNT)
                        pos = back ? ENTRY_COUNT - 1 : 0;
                    if (written_tab[pos[INDEX_W-1:0]] && kind_tab[pos[INDEX_W-1:0]] == kind)
                    begin
                        reply.found = 1'b1;
                        reply.index = pos[INDEX_W-1:0];
                    end
                    else
                        pos = back ? pos - 1 : pos + 1;
                end
            end
            OP_FIND_NAME:
            begin
                words = packed_name(chars);
                for (int i = idx; i < ENTRY_COUNT && !reply.found; i++)
                begin
                    if (written_tab[i[INDEX_W-1:0]]
                        && name_high_tab[i[INDEX_W-1:0]] == words[2*WORD_W-1:WORD_W]
                        && name_low_tab[i[INDEX_W-1:0]] == words[WORD_W-1:0]
                        && kind_tab[i[INDEX_W-1:0]] == kind)
                    begin
                        reply.found = 1'b1;
                        reply.index = i[INDEX_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        return reply;
    endfunction

    always @(posedge clk)
    begin
        lookup_reply_t want;
        if (rst_n)
        begin
            // retire the oldest expectation before queuing a new one
            if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected result found=%0d match_index=%0d",
                             $time, found, match_index);
                    fail_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (found !== want.found)
                    begin
                        $display("%0t: found expected %0d actual %0d",
                                 $time, want.found, found);
                        fail_count++;
                    end
                    if (match_index !== want.index)
                    begin
                        $display("%0t: match_index expected %0d actual %0d",
                                 $time, want.index, match_index);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_replies.push_back(predict_lookup(opcode, entry_index,
                    write_name_low, write_name_high, file_kind, search_backward,
                    name_bytes));
            outstanding = expected_replies.size();
        end
    end

endmodule

### test/file_entry_table_search_test.sv
`timescale 1ns / 1ps
module file_entry_table_search_test;

    import fet_pkg::*;

    // Opcode the block decodes as a no-op
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // A type-search miss scans the whole table, and idle gaps may come between
    // transactions. Take roughly five times the slowest clean run.
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_ITEMS = 265;
    localparam int DRAIN_CYCLES = 8;
    localparam int POOL_SIZE    = 12;
    localparam int COMMON_KINDS = 6;

    localparam logic [7:0] NAME_NUL = 8'h00;
    localparam logic [7:0] NAME_DOT = 8'h2E;

    // Names used in the directed part, first character in the lowest byte
    localparam logic [63:0] NAME_SHORT    = 64'h0000_0000_0000_4241; // "AB"
    localparam logic [63:0] NAME_FULL     = 64'h5A59_5857_5655_5453; // eight letters
    localparam logic [63:0] NAME_DOT_LOW  = 64'h7E7E_7E7E_4342_2E41; // dot in low half
    localparam logic [63:0] NAME_DOT_HIGH = 64'h4141_412E_4242_4242; // dot opens high half
    localparam logic [63:0] NAME_SIGNED   = 64'hFFFF_FFFF_FFFF_FFFF; // bytes above 0x7F
    localparam logic [63:0] NAME_CONTROL  = 64'h0101_0101_1F1F_0101; // below the bias
    localparam logic [63:0] NAME_EMPTY    = 64'hFFFF_FFFF_FFFF_FF00; // NUL first

    typedef struct {
        logic [INDEX_W-1:0]      index;
        logic [8*NAME_CHARS-1:0] chars;
        logic [KIND_W-1:0]       kind;
    } stored_name_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               opcode;
    logic [INDEX_W-1:0]       entry_index;
    logic [WORD_W-1:0]        write_name_low;
    logic [WORD_W-1:0]        write_name_high;
    logic [KIND_W-1:0]        file_kind;
    logic                     search_backward;
    logic [8*NAME_CHARS-1:0]  name_bytes;
    logic                     done;
    logic                     found;
    logic [INDEX_W-1:0]       match_index;

    int                       mismatches;
    int                       outstanding;
    int                       cycle_count;
    bit                       burst;

    // Entries written with a packed name, kept to aim name searches at them
    stored_name_t             stored_names [$];
    logic [8*NAME_CHARS-1:0]  name_pool [POOL_SIZE];

    file_entry_table_search uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .entry_index     (entry_index),
        .write_name_low  (write_name_low),
        .write_name_high (write_name_high),
        .file_kind       (file_kind),
        .search_backward (search_backward),
        .name_bytes      (name_bytes),
        .done            (done),
        .found           (found),
        .match_index     (match_index)
    );

    // Watch both sides, predict every transaction and compare the results
    file_entry_table_search_check lookup_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .entry_index     (entry_index),
        .write_name_low  (write_name_low),
        .write_name_high (write_name_high),
        .file_kind       (file_kind),
        .search_backward (search_backward),
        .name_bytes      (name_bytes),
        .done            (done),
        .found           (found),
        .match_index     (match_index),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: end the run if the block hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("file_entry_table_search test failed");
        $finish;
    end

    // Build the stored words for a name so that later name searches can hit.
    // Same packing rule as the block: six bits per character, signed bytes
    // biased by 0x20, stop at NUL or dot, second word from character four.
    function automatic logic [2*WORD_W-1:0] name_words(input logic [8*NAME_CHARS-1:0] chars);
        logic [WORD_W-1:0] word_pair [2];
        logic [7:0]        ch;
        int                shift;
        bit                stopped;
        word_pair[0] = '0;
        word_pair[1] = '0;
        shift        = 0;
        stopped      = 1'b0;
        for (int k = 0; k < NAME_CHARS; k++)
        begin
            ch = chars[8*k +: 8];
            if (k == HALF_CHARS)
                shift = 0;
            stopped |= (ch == NAME_NUL || ch == NAME_DOT);
            if (!stopped)
            begin
                word_pair[k / HALF_CHARS] |= ({{(WORD_W-8){ch[7]}}, ch} - 32'h20) << shift;
                shift += CHAR_STEP;
            end
        end
        return {word_pair[1], word_pair[0]};
    endfunction

    // Mostly printable characters; now and then a terminator, a byte with
    // the top bit set, or a control byte that packs as a negative value
    function automatic logic [8*NAME_CHARS-1:0] random_name();
        logic [8*NAME_CHARS-1:0] chars;
        int                      r;
        for (int k = 0; k < NAME_CHARS; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                chars[8*k +: 8] = 8'($urandom_range(8'h21, 8'h7E));
            else if (r < 82)
                chars[8*k +: 8] = NAME_DOT;
            else if (r < 88)
                chars[8*k +: 8] = NAME_NUL;
            else if (r < 95)
                chars[8*k +: 8] = 8'($urandom_range(8'h80, 8'hFF));
            else
                chars[8*k +: 8] = 8'($urandom_range(8'h01, 8'h1F));
        end
        return chars;
    endfunction

    // Idle time before the next transaction: mostly none or short, a few
    // long gaps, and bursts where the sender never pauses
    function automatic int idle_cycles();
        int r;
        if ($urandom_range(0, 29) == 0)
            burst = !burst;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Drive one transaction and hold it until the block takes it. Return
    // at the accepting edge with start still high, so a back-to-back
    // transaction keeps start asserted instead of dropping it.
    task automatic send(
        input logic [1:0]              op,
        input logic [INDEX_W-1:0]      idx,
        input logic [WORD_W-1:0]       lo,
        input logic [WORD_W-1:0]       hi,
        input logic [KIND_W-1:0]       kind,
        input logic                    back,
        input logic [8*NAME_CHARS-1:0] chars
    );
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode          <= op;
        entry_index     <= idx;
        write_name_low  <= lo;
        write_name_high <= hi;
        file_kind       <= kind;
        search_backward <= back;
        name_bytes      <= chars;
        start           <= 1'b1;
        // busy read here is its value at the edge just passed
        do
            @(posedge clk);
        while (busy);
    endtask

    // Write an entry holding the packed form of a name and remember it
    task automatic store_entry(
        input logic [INDEX_W-1:0]      idx,
        input logic [8*NAME_CHARS-1:0] chars,
        input logic [KIND_W-1:0]       kind
    );
        logic [2*WORD_W-1:0] words;
        stored_name_t        rec;
        words     = name_words(chars);
        rec.index = idx;
        rec.chars = chars;
        rec.kind  = kind;
        stored_names.push_back(rec);
        send(OP_WRITE, idx, words[WORD_W-1:0], words[2*WORD_W-1:WORD_W], kind,
             1'($urandom_range(0, 1)), chars);
    endtask

    initial
    begin
        int                      choice;
        int                      span;
        int                      pick;
        logic [INDEX_W-1:0]      idx;
        logic [KIND_W-1:0]       kind;
        stored_name_t            rec;

        // Hold every input at a known value through reset
        rst_n           <= 1'b0;
        start           <= 1'b0;
        opcode          <= OP_WRITE;
        entry_index     <= '0;
        write_name_low  <= '0;
        write_name_high <= '0;
        file_kind       <= '0;
        search_backward <= 1'b0;
        name_bytes      <= '0;
        burst            = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < POOL_SIZE; p++)
            name_pool[p] = random_name();

        // ---- Directed part ----
        // Searches on an empty table: unwritten entries must never match,
        // even for kind 0 and an empty name that equal the cleared content
        send(OP_FIND_KIND, 11'd0, '0, '0, 4'd0, 1'b0, '0);
        send(OP_FIND_NAME, 11'd0, '0, '0, 4'd0, 1'b0, NAME_EMPTY);

        // Populate the table edges and a few names that stress the packer
        store_entry(11'd0,    NAME_SHORT,    4'd5);
        store_entry(11'd2047, NAME_DOT_LOW,  4'd5);
        store_entry(11'd1,    NAME_SIGNED,   4'd15);
        store_entry(11'd1024, NAME_EMPTY,    4'd0);
        store_entry(11'd1500, NAME_FULL,     4'd9);
        store_entry(11'd600,  NAME_CONTROL,  4'd3);
        store_entry(11'd700,  NAME_DOT_HIGH, 4'd3);
        send(OP_WRITE, 11'd800, '1, '1, 4'd15, 1'b1, '1);

        // Unused opcode: no effect, empty result
        send(OP_RESERVED, 11'd2047, '1, '1, '1, 1'b1, '1);

        // Type search wrap in both directions; the start itself comes last
        send(OP_FIND_KIND, 11'd2047, '0, '0, 4'd5,  1'b0, '0);
        send(OP_FIND_KIND, 11'd0,    '0, '0, 4'd5,  1'b1, '0);
        send(OP_FIND_KIND, 11'd1,    '0, '0, 4'd15, 1'b1, '0);
        send(OP_FIND_KIND, 11'd1024, '0, '0, 4'd0,  1'b0, '0);
        send(OP_FIND_KIND, 11'd0,    '0, '0, 4'd7,  1'b0, '0);

        // Name search: hit at the start, no wrap past the end, kind must match
        send(OP_FIND_NAME, 11'd0,    '0, '0, 4'd5,  1'b0, NAME_SHORT);
        send(OP_FIND_NAME, 11'd1,    '0, '0, 4'd5,  1'b0, NAME_SHORT);
        send(OP_FIND_NAME, 11'd2047, '0, '0, 4'd5,  1'b0, NAME_DOT_LOW);
        send(OP_FIND_NAME, 11'd0,    '0, '0, 4'd15, 1'b0, NAME_SIGNED);
        send(OP_FIND_NAME, 11'd0,    '0, '0, 4'd8,  1'b0, NAME_FULL);
        send(OP_FIND_NAME, 11'd600,  '0, '0, 4'd3,  1'b0, NAME_DOT_HIGH);
        send(OP_FIND_NAME, 11'd0,    '0, '0, 4'd3,  1'b0, NAME_CONTROL);

        // Overwrite an entry and find the new content
        store_entry(11'd0, NAME_EMPTY, 4'd0);
        send(OP_FIND_NAME, 11'd0, '0, '0, 4'd0, 1'b0, NAME_EMPTY);

        // ---- Random part ----
        // Mostly writes of pool names followed by searches aimed at them,
        // with noise writes, stray names, type searches and unused opcodes mixed in
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            choice = $urandom_range(0, 99);
            kind   = KIND_W'(($urandom_range(0, 6) != 0) ? $urandom_range(0, COMMON_KINDS - 1)
                                                         : $urandom_range(0, 15));
            if (choice < 30)
            begin
                idx = INDEX_W'($urandom_range(0, 1) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 2047));
                store_entry(idx, ($urandom_range(0, 4) != 0) ? name_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                             : random_name(), kind);
            end
            else if (choice < 35)
                send(OP_WRITE, INDEX_W'($urandom_range(0, 2047)), $urandom, $urandom,
                     KIND_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                     {$urandom, $urandom});
            else if (choice < 62)
            begin
                // Start at or below a stored entry, usually close to it
                pick = $urandom_range(0, stored_names.size() - 1);
                rec  = stored_names[pick];
                if ($urandom_range(0, 3) == 0)
                    idx = INDEX_W'($urandom_range(0, rec.index));
                else
                begin
                    span = (rec.index < 64) ? int'(rec.index) : 64;
                    idx  = rec.index - INDEX_W'($urandom_range(0, span));
                end
                send(OP_FIND_NAME, idx, $urandom, $urandom,
                     ($urandom_range(0, 9) != 0) ? rec.kind : kind, 1'($urandom_range(0, 1)),
                     rec.chars);
            end
            else if (choice < 72)
                send(OP_FIND_NAME, INDEX_W'($urandom_range(0, 2047)), $urandom, $urandom, kind,
                     1'($urandom_range(0, 1)),
                     $urandom_range(0, 1) ? random_name() : {$urandom, $urandom});
            else if (choice < 95)
                send(OP_FIND_KIND, INDEX_W'($urandom_range(0, 2047)), $urandom, $urandom, kind,
                     1'($urandom_range(0, 1)), {$urandom, $urandom});
            else
                send(OP_RESERVED, INDEX_W'($urandom_range(0, 2047)), $urandom, $urandom,
                     KIND_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                     {$urandom, $urandom});
        end

        // Drop start and drain: wait for every expected result, then wait
        // DRAIN_CYCLES longer to catch stray strobes
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("file_entry_table_search test passed");
        else
            $display("file_entry_table_search test failed");
        $finish;
    end

endmodule
